// ===== hw/rtl/si1dec_pkg.sv =====
// Shared types, constants and decode functions of the SI1 channel decoder.
`default_nettype none
package si1dec_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0] LAST_CCD_OCTET = 5'd15;
  localparam logic [4:0] RACH_OCTET0 = 5'd16;
  localparam logic [4:0] RACH_OCTET1 = 5'd17;
  localparam logic [4:0] RACH_OCTET2 = 5'd18;

  localparam logic [2:0] FMT_BITMAP0 = 3'd0;
  localparam logic [2:0] FMT_RANGE1024 = 3'd1;
  localparam logic [2:0] FMT_RANGE512 = 3'd2;
  localparam logic [2:0] FMT_RANGE256 = 3'd3;
  localparam logic [2:0] FMT_RANGE128 = 3'd4;
  localparam logic [2:0] FMT_VARIABLE = 3'd5;
  localparam logic [2:0] FMT_RESERVED = 3'd6;

  localparam logic [7:0] ID_MASK = 8'hc0;
  localparam logic [7:0] ID_BITMAP0 = 8'h00;
  localparam logic [7:0] ID_RANGE = 8'h80;
  localparam logic [7:0] OCTET0_MASK = 8'h0f;

  typedef struct packed {
    logic       is_summary;
    logic [3:0] octet;
    logic [2:0] fmt;
    logic [7:0] bits;
    logic [7:0] rach;
    logic [7:0] high;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [2:0] classify(input logic [7:0] b);
    logic [2:0] f;
    if ((b & ID_MASK) == ID_BITMAP0) begin
      f = FMT_BITMAP0;
    end else if ((b & ID_MASK) != ID_RANGE) begin
      f = FMT_RESERVED;
    end else if (b[3] == 1'b0) begin
      f = FMT_RANGE1024;
    end else begin
      unique case (b[2:1])
        2'b00: f = FMT_RANGE512;
        2'b01: f = FMT_RANGE256;
        2'b10: f = FMT_RANGE128;
        default: f = FMT_VARIABLE;
      endcase
    end
    return f;
  endfunction

  function automatic logic [2:0] retx_decode(input logic [1:0] code);
    logic [2:0] r;
    unique case (code)
      2'd0: r = 3'd1;
      2'd1: r = 3'd2;
      2'd2: r = 3'd4;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] tx_decode(input logic [3:0] code);
    logic [5:0] t;
    unique case (code)
      4'd0: t = 6'd3;
      4'd1: t = 6'd4;
      4'd2: t = 6'd5;
      4'd3: t = 6'd6;
      4'd4: t = 6'd7;
      4'd5: t = 6'd8;
      4'd6: t = 6'd9;
      4'd7: t = 6'd10;
      4'd8: t = 6'd11;
      4'd9: t = 6'd12;
      4'd10: t = 6'd14;
      4'd11: t = 6'd16;
      4'd12: t = 6'd20;
      4'd13: t = 6'd25;
      4'd14: t = 6'd32;
      default: t = 6'd50;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/si1dec_if.sv =====
// Valid/ready channel interfaces for octet input and decoded result output.
`default_nettype none
interface si1dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

interface si1dec_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  channel_number;
  logic [2:0]  list_format;
  logic [2:0]  max_retransmissions;
  logic [5:0]  tx_integer;
  logic        cell_barred;
  logic        reestablish_barred;
  logic        emergency_barred;
  logic [15:0] access_classes;
  logic        last;

  modport source (
    output valid, output kind, output channel_number, output list_format,
    output max_retransmissions, output tx_integer, output cell_barred,
    output reestablish_barred, output emergency_barred, output access_classes,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input channel_number, input list_format,
    input max_retransmissions, input tx_integer, input cell_barred,
    input reestablish_barred, input emergency_barred, input access_classes,
    input last, output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/gsm_si1_cell_channel_decoder.sv =====
// GSM SI1 decoder: the input channel takes the 19 body octets of a System
// Information Type 1 message, one octet per transaction. Octet 0 selects the
// channel list format; in the bit map 0 format each set bit of octets 0 to 15
// becomes one channel number transaction on the result channel, lowest bit
// first. After octet 18 one summary transaction carries the format, the RACH
// control fields and the access classes, with last set. start_req restarts a
// message at any octet.
// The front end takes one octet per cycle unless the job queue is full, and
// queues work for the back end; the back end issues one result per cycle while
// the receiver is ready, so a bitmap octet with k set bits gives k results in
// turn. A job passes from the queue through the work register to the output
// register. Input ready drops only while the four-entry job queue is full.
// Reset clears the octet position, the format, the queue and the output valid.
// While the receiver stalls, the output register holds its transaction and
// the queue absorbs up to four more jobs before input ready drops.
`default_nettype none
module gsm_si1_cell_channel_decoder import si1dec_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  si1dec_in_if.sink    in_ch,
  si1dec_out_if.source out_ch
);

  logic      push, pop;
  job_t      push_job, head;
  q_status_t q_stat;

  si1dec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  si1dec_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  si1dec_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/si1dec_front.sv =====
// Front end: tracks the octet position, classifies the format and queues jobs.
`default_nettype none
module si1dec_front import si1dec_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  si1dec_in_if.sink      in_ch,
  input  wire q_status_t q_stat,
  output logic           push,
  output job_t           push_job
);

  logic [4:0] octet_index_r, octet_index_nxt;
  logic [2:0] format_code_r, format_code_nxt;
  logic [7:0] rach_first_octet_r, rach_first_octet_nxt;
  logic [7:0] access_high_octet_r, access_high_octet_nxt;
  logic       accept;
  logic [4:0] idx;
  logic [2:0] fmt;
  logic [7:0] bits;

  assign in_ch.ready = !q_stat.full;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    idx = (in_ch.start_req || octet_index_r > RACH_OCTET2) ? 5'd0 : octet_index_r;
    fmt = (idx == 5'd0) ? classify(in_ch.data_byte) : format_code_r;
    bits = (idx == 5'd0) ? (in_ch.data_byte & OCTET0_MASK) : in_ch.data_byte;

    octet_index_nxt = octet_index_r;
    format_code_nxt = format_code_r;
    rach_first_octet_nxt = rach_first_octet_r;
    access_high_octet_nxt = access_high_octet_r;
    push = 1'b0;
    push_job.is_summary = 1'b0;
    push_job.octet = idx[3:0];
    push_job.fmt = fmt;
    push_job.bits = bits;
    push_job.rach = rach_first_octet_r;
    push_job.high = access_high_octet_r;

    if (accept) begin
      if (idx <= LAST_CCD_OCTET) begin
        format_code_nxt = fmt;
        octet_index_nxt = idx + 5'd1;
        push = (fmt == FMT_BITMAP0) && (bits != 8'd0);
      end else if (idx == RACH_OCTET0) begin
        rach_first_octet_nxt = in_ch.data_byte;
        octet_index_nxt = RACH_OCTET1;
      end else if (idx == RACH_OCTET1) begin
        access_high_octet_nxt = in_ch.data_byte;
        octet_index_nxt = RACH_OCTET2;
      end else begin
        push = 1'b1;
        push_job.is_summary = 1'b1;
        push_job.fmt = format_code_r;
        push_job.bits = in_ch.data_byte;
        octet_index_nxt = 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octet_index_r <= 5'd0;
      format_code_r <= FMT_BITMAP0;
      rach_first_octet_r <= 8'd0;
      access_high_octet_r <= 8'd0;
    end else begin
      octet_index_r <= octet_index_nxt;
      format_code_r <= format_code_nxt;
      rach_first_octet_r <= rach_first_octet_nxt;
      access_high_octet_r <= access_high_octet_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/si1dec_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none
module si1dec_queue import si1dec_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire job_t  push_job,
  input  wire logic  pop,
  output job_t       head,
  output q_status_t  q_stat
);

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign q_stat.empty = (count_r == QCNT_W'(0));
  assign q_stat.full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push && !q_stat.full;
  assign do_pop = pop && !q_stat.empty;
  assign head = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/si1dec_back.sv =====
// Back end: expands bitmap octets into channel items and builds the summary.
`default_nettype none
module si1dec_back import si1dec_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire job_t      head,
  input  wire q_status_t q_stat,
  output logic           pop,
  si1dec_out_if.source   out_ch
);

  job_t       work_r, work_nxt;
  logic       work_valid_r, work_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_load, emit, done;
  logic [2:0] bit_sel;
  logic [7:0] rest;

  always_comb begin
    bit_sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (work_r.bits[i]) begin
        bit_sel = 3'(i);
      end
    end
  end

  assign rest = work_r.bits & ~(8'd1 << bit_sel);
  assign can_load = !out_valid_r || out_ch.ready;
  assign emit = work_valid_r && can_load;
  assign done = work_r.is_summary || (rest == 8'd0);
  assign pop = !q_stat.empty && (!work_valid_r || (emit && done));

  always_comb begin
    work_nxt = work_r;
    work_valid_nxt = work_valid_r;
    if (pop) begin
      work_nxt = head;
      work_valid_nxt = 1'b1;
    end else if (emit && done) begin
      work_valid_nxt = 1'b0;
    end else if (emit) begin
      work_nxt.bits = rest;
    end
    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (emit) begin
      out_ch.list_format <= work_r.fmt;
      out_ch.kind <= work_r.is_summary;
      out_ch.last <= work_r.is_summary;
      if (work_r.is_summary) begin
        out_ch.channel_number <= 7'd0;
        out_ch.max_retransmissions <= retx_decode(work_r.rach[7:6]);
        out_ch.tx_integer <= tx_decode(work_r.rach[5:2]);
        out_ch.cell_barred <= work_r.rach[1];
        out_ch.reestablish_barred <= work_r.rach[0];
        out_ch.emergency_barred <= work_r.high[0];
        out_ch.access_classes <= {work_r.high, work_r.bits};
      end else begin
        out_ch.channel_number <= {~work_r.octet, bit_sel} + 7'd1;
        out_ch.max_retransmissions <= 3'd0;
        out_ch.tx_integer <= 6'd0;
        out_ch.cell_barred <= 1'b0;
        out_ch.reestablish_barred <= 1'b0;
        out_ch.emergency_barred <= 1'b0;
        out_ch.access_classes <= 16'd0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hw/rtl/si1dec_checker.sv =====
// Port-level checker for the SI1 decoder, bound to the top level.
`default_nettype none
module si1dec_checker import si1dec_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        kind,
  input wire logic        last,
  input wire logic [6:0]  channel_number,
  input wire logic [2:0]  list_format,
  input wire logic [15:0] access_classes
);

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result valid dropped before the transaction completed.");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(channel_number) && $stable(kind) &&
      $stable(access_classes))
    else $error("Result payload changed while stalled.");

  a_channel_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !kind |-> !last && channel_number != 7'd0 &&
      channel_number <= 7'd124 && list_format == FMT_BITMAP0)
    else $error("Malformed channel number transaction.");

  a_summary_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind |-> last && channel_number == 7'd0)
    else $error("Malformed summary transaction.");

endmodule

bind gsm_si1_cell_channel_decoder si1dec_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .kind           (out_ch.kind),
  .last           (out_ch.last),
  .channel_number (out_ch.channel_number),
  .list_format    (out_ch.list_format),
  .access_classes (out_ch.access_classes)
);
`default_nettype wire

// ===== tb/sv/tb_gsm_si1_cell_channel_decoder.sv =====
// Testbench for the SI1 decoder: directed and random messages against an in-line decode model.
`timescale 1ns / 1ps
module tb_gsm_si1_cell_channel_decoder;
  import si1dec_pkg::*;

  localparam int ITEM_TARGET = 210;
  localparam int DIRECTED_ITEMS = 60;
  localparam int CALM_ITEMS = 60;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT = 34;

  localparam logic [95:0] TX_SLOTS = {
    6'd50, 6'd32, 6'd25, 6'd20, 6'd16, 6'd14, 6'd12, 6'd11,
    6'd10, 6'd9, 6'd8, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3
  };
  localparam logic [11:0] RETX_COUNTS = {3'd7, 3'd4, 3'd2, 3'd1};

  typedef struct packed {
    logic        kind;
    logic [6:0]  channel_number;
    logic [2:0]  list_format;
    logic [2:0]  max_retransmissions;
    logic [5:0]  tx_integer;
    logic        cell_barred;
    logic        reestablish_barred;
    logic        emergency_barred;
    logic [15:0] access_classes;
    logic        last;
  } decoded_t;

  logic clk;
  logic rst_n;

  si1dec_in_if  in_ch();
  si1dec_out_if out_ch();

  gsm_si1_cell_channel_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decoded_t   expected_decodes[$];
  logic [4:0] octet_pos;
  logic [2:0] cur_format;
  logic [7:0] rach_octet;
  logic [7:0] access_hi;
  int         mismatch_count;
  int         hold_off_left;
  int         idle_run;
  bit         tx_idle_en;
  bit         rx_idle_en;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [2:0] list_format_of(input logic [7:0] b);
    if (b[7:6] == 2'b00) begin
      return FMT_BITMAP0;
    end
    if (b[7:6] != 2'b10) begin
      return FMT_RESERVED;
    end
    if (!b[3]) begin
      return FMT_RANGE1024;
    end
    case (b[2:1])
      2'b00: return FMT_RANGE512;
      2'b01: return FMT_RANGE256;
      2'b10: return FMT_RANGE128;
      default: return FMT_VARIABLE;
    endcase
  endfunction

  task automatic decode_octet(input logic [7:0] octet, input logic start);
    decoded_t   item;
    logic [7:0] bits;
    int         j;
    if (start || octet_pos > RACH_OCTET2) begin
      octet_pos = 5'd0;
    end
    if (octet_pos <= LAST_CCD_OCTET) begin
      bits = octet;
      if (octet_pos == 5'd0) begin
        cur_format = list_format_of(octet);
        bits = octet & OCTET0_MASK;
      end
      if (cur_format == FMT_BITMAP0) begin
        for (j = 0; j < 8; j++) begin
          if (bits[j]) begin
            item = '0;
            item.channel_number = 7'((15 - int'(octet_pos)) * 8 + j + 1);
            item.list_format = cur_format;
            expected_decodes.push_back(item);
          end
        end
      end
      octet_pos = octet_pos + 5'd1;
    end else if (octet_pos == RACH_OCTET0) begin
      rach_octet = octet;
      octet_pos = RACH_OCTET1;
    end else if (octet_pos == RACH_OCTET1) begin
      access_hi = octet;
      octet_pos = RACH_OCTET2;
    end else begin
      item = '0;
      item.kind = 1'b1;
      item.list_format = cur_format;
      item.max_retransmissions = RETX_COUNTS[rach_octet[7:6] * 3 +: 3];
      item.tx_integer = TX_SLOTS[rach_octet[5:2] * 6 +: 6];
      item.cell_barred = rach_octet[1];
      item.reestablish_barred = rach_octet[0];
      item.emergency_barred = access_hi[0];
      item.access_classes = {access_hi, octet};
      item.last = 1'b1;
      expected_decodes.push_back(item);
      octet_pos = 5'd0;
    end
  endtask

  task automatic send_octet(input logic [7:0] octet, input logic start);
    @(negedge clk);
    if (tx_idle_en) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= octet;
    in_ch.start_req <= start;
    do @(posedge clk); while (!in_ch.ready);
    decode_octet(octet, start);
  endtask

  task automatic send_message(input logic [7:0] octet0, input logic start, input logic [7:0] fill,
                              input logic [7:0] r0, input logic [7:0] r1, input logic [7:0] r2);
    int k;
    send_octet(octet0, start);
    for (k = 1; k <= 15; k++) begin
      send_octet(fill, 1'b0);
    end
    send_octet(r0, 1'b0);
    send_octet(r1, 1'b0);
    send_octet(r2, 1'b0);
  endtask

  function automatic logic [7:0] random_format_octet();
    logic [7:0] b;
    int         pick;
    b = 8'($urandom);
    pick = $urandom_range(9);
    if (pick <= 3) begin
      b[7:6] = 2'b00;
    end else if (pick == 4) begin
      b[7:6] = 2'b10;
      b[3] = 1'b0;
    end else if (pick <= 8) begin
      b[7:6] = 2'b10;
      b[3] = 1'b1;
      b[2:1] = 2'(pick - 5);
    end else begin
      b[7:6] = $urandom_range(1) ? 2'b11 : 2'b01;
    end
    return b;
  endfunction

  function automatic logic [7:0] random_body_octet();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_full_bitmap();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_message(8'h0f, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
  endtask

  task automatic test_restart_mid_message();
    send_octet(8'h80, 1'b0);
    send_octet(8'h5a, 1'b0);
    send_octet(8'ha5, 1'b0);
    send_message(8'h88, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_receiver_backpressure();
    tx_idle_en = 1'b0;
    hold_off_left = HOLD_OFF_CYCLES;
    send_message(8'h0f, 1'b0, 8'hff, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_random_messages(input int item_count, input bit idle);
    int   sent;
    int   cut;
    int   k;
    bit   need_start;
    logic start;
    tx_idle_en = idle;
    rx_idle_en = idle;
    sent = 0;
    need_start = 1'b0;
    while (sent < item_count) begin
      cut = ($urandom_range(99) < 20) ? $urandom_range(17, 1) : 19;
      if (cut > item_count - sent) begin
        cut = item_count - sent;
      end
      for (k = 0; k < cut; k++) begin
        start = (k == 0) ? (need_start | 1'($urandom_range(1))) : 1'b0;
        send_octet((k == 0) ? random_format_octet() : random_body_octet(), start);
        sent++;
      end
      need_start = (cut < 19);
    end
  endtask

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else if (rx_idle_en) begin
      out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp, input logic [15:0] act);
    if (act !== exp) begin
      $error("%s: expected %0d, actual %0d", name, exp, act);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    decoded_t exp;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (expected_decodes.size() == 0) begin
        $error("result transaction with no expected decode pending");
        mismatch_count++;
      end else begin
        exp = expected_decodes.pop_front();
        check_field("kind", 16'(exp.kind), 16'(out_ch.kind));
        check_field("channel_number", 16'(exp.channel_number), 16'(out_ch.channel_number));
        check_field("list_format", 16'(exp.list_format), 16'(out_ch.list_format));
        check_field("max_retransmissions", 16'(exp.max_retransmissions),
                    16'(out_ch.max_retransmissions));
        check_field("tx_integer", 16'(exp.tx_integer), 16'(out_ch.tx_integer));
        check_field("cell_barred", 16'(exp.cell_barred), 16'(out_ch.cell_barred));
        check_field("reestablish_barred", 16'(exp.reestablish_barred),
                    16'(out_ch.reestablish_barred));
        check_field("emergency_barred", 16'(exp.emergency_barred),
                    16'(out_ch.emergency_barred));
        check_field("access_classes", exp.access_classes, out_ch.access_classes);
        check_field("last", 16'(exp.last), 16'(out_ch.last));
      end
    end
  end

  initial begin
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.start_req = 1'b0;
    out_ch.ready = 1'b0;
    octet_pos = 5'd0;
    cur_format = FMT_BITMAP0;
    rach_octet = 8'h00;
    access_hi = 8'h00;
    mismatch_count = 0;
    hold_off_left = 0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_full_bitmap();
    test_restart_mid_message();
    test_receiver_backpressure();
    test_random_messages(CALM_ITEMS, 1'b0);
    test_random_messages(ITEM_TARGET - DIRECTED_ITEMS - CALM_ITEMS, 1'b1);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_decodes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
